/* src/pgr_pkg.sv */
// Package for the pointer gesture recognizer: gesture and mode codes,
// register indexes, field widths and reset values. No dependencies.
package pgr_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int MODE_W  = 3;
    localparam int BTN_W   = 3;
    localparam int GEST_W  = 4;
    localparam int MDRAG_W = 8;
    localparam int LONG_W  = 16;
    localparam int MOT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Result queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_TICKS = 2'd2;

    localparam logic [MDRAG_W-1:0] MIN_DRAG_RST     = 8'd5;
    localparam logic [LONG_W-1:0]  LONG_TICKS_RST   = 16'd1000;
    localparam logic [MOT_W-1:0]   MOTION_TICKS_RST = 10'd30;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_PRESS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCROLL  = 3'd4;

    // Buttons
    localparam logic [BTN_W-1:0] BTN_LEFT   = 3'd1;
    localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'd2;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 3'd3;

    // Gesture codes
    localparam logic [GEST_W-1:0] G_SHORT       = 4'd0;
    localparam logic [GEST_W-1:0] G_LONG        = 4'd1;
    localparam logic [GEST_W-1:0] G_MIDDLE      = 4'd2;
    localparam logic [GEST_W-1:0] G_RIGHT       = 4'd3;
    localparam logic [GEST_W-1:0] G_PRESSED     = 4'd4;
    localparam logic [GEST_W-1:0] G_RELEASED    = 4'd5;
    localparam logic [GEST_W-1:0] G_DRAG_START  = 4'd6;
    localparam logic [GEST_W-1:0] G_MOTION      = 4'd7;
    localparam logic [GEST_W-1:0] G_DRAG_END    = 4'd8;
    localparam logic [GEST_W-1:0] G_SCROLL_UP   = 4'd9;
    localparam logic [GEST_W-1:0] G_SCROLL_DOWN = 4'd10;

    // Push request from front to queue
    typedef struct packed {
        logic push_one;
        logic push_two;
    } t_push;

endpackage

/* src/pgr_front.sv */
// Front end: configuration registers, gesture state and classification
// of each input transaction into up to two events. Depends on pgr_pkg.
module pgr_front #(
    parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pgr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    input  logic [pgr_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [pgr_pkg::BTN_W-1:0]    i_button,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic                                i_press_claimed,
    input  logic                                i_room,
    output pgr_pkg::t_push                      o_push,
    output logic [2*COORD_BITS+pgr_pkg::GEST_W:0] o_evt0,
    output logic [2*COORD_BITS+pgr_pkg::GEST_W:0] o_evt1
);
    localparam int GW = pgr_pkg::GEST_W;
    localparam int LW = pgr_pkg::LONG_W;
    localparam int MW = pgr_pkg::MOT_W;

    logic [pgr_pkg::MDRAG_W-1:0] r_min_drag;
    logic [LW-1:0]               r_long_ticks;
    logic [MW-1:0]               r_motion_ticks;

    logic r_held, r_blocked, r_drag, r_mot_on, r_long_on;
    logic n_held, n_blocked, n_drag, n_mot_on, n_long_on;
    logic [LW-1:0] r_long_cnt, n_long_cnt;
    logic [MW-1:0] r_mot_cnt, n_mot_cnt;
    logic [COORD_BITS-1:0] r_sx, r_sy, n_sx, n_sy;

    logic          accept;
    logic [GW-1:0] g0, g1;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic          two, any;

    logic signed [COORD_BITS:0] dx_s, dy_s;
    logic [COORD_BITS:0]        dx_a, dy_a, mdrag_ext;
    logic                       moved_far;
    logic [LW:0]                long_next;
    logic [MW:0]                mot_next;
    logic                       long_fire, mot_fire;

    assign accept = i_valid && i_room;

    // Per-axis distance from the latched press point
    assign dx_s = {i_pos_x[COORD_BITS-1], i_pos_x} - {r_sx[COORD_BITS-1], r_sx};
    assign dy_s = {i_pos_y[COORD_BITS-1], i_pos_y} - {r_sy[COORD_BITS-1], r_sy};
    assign dx_a = dx_s[COORD_BITS] ? (~dx_s + 1'b1) : dx_s;
    assign dy_a = dy_s[COORD_BITS] ? (~dy_s + 1'b1) : dy_s;
    assign mdrag_ext = {{(COORD_BITS + 1 - pgr_pkg::MDRAG_W){1'b0}}, r_min_drag};
    assign moved_far = (dx_a > mdrag_ext) || (dy_a > mdrag_ext);

    // Timers; a period of zero fires on the first tick
    assign long_next = {1'b0, r_long_cnt} + 1'b1;
    assign mot_next  = {1'b0, r_mot_cnt} + 1'b1;
    assign long_fire = r_long_on && (long_next >= {1'b0, r_long_ticks});
    assign mot_fire  = r_mot_on && (mot_next >= {1'b0, r_motion_ticks});

    always_comb begin
        n_held     = r_held;
        n_blocked  = r_blocked;
        n_drag     = r_drag;
        n_mot_on   = r_mot_on;
        n_long_on  = r_long_on;
        n_long_cnt = r_long_cnt;
        n_mot_cnt  = r_mot_cnt;
        n_sx       = r_sx;
        n_sy       = r_sy;
        g0  = pgr_pkg::G_RELEASED;
        g1  = pgr_pkg::G_RELEASED;
        x0  = i_pos_x;
        y0  = i_pos_y;
        x1  = i_pos_x;
        y1  = i_pos_y;
        any = 1'b0;
        two = 1'b0;
        case (i_mode)
            pgr_pkg::MODE_PRESS: begin
                n_sx      = i_pos_x;
                n_sy      = i_pos_y;
                g0        = pgr_pkg::G_PRESSED;
                any       = 1'b1;
                n_blocked = i_press_claimed;
                n_held    = 1'b1;
                if (i_button == pgr_pkg::BTN_LEFT) begin
                    n_long_on  = 1'b1;
                    n_long_cnt = '0;
                end
            end
            pgr_pkg::MODE_RELEASE: begin
                any = 1'b1;
                // RELEASED goes last; a drag end or click may precede it
                if (r_drag) begin
                    n_mot_on = 1'b0;
                    n_drag   = 1'b0;
                    n_held   = 1'b0;
                    g0       = pgr_pkg::G_DRAG_END;
                    two      = 1'b1;
                end else if (r_held) begin
                    n_long_on = 1'b0;
                    n_held    = 1'b0;
                    if (i_button == pgr_pkg::BTN_LEFT) begin
                        g0  = pgr_pkg::G_SHORT;
                        two = 1'b1;
                    end else if (i_button == pgr_pkg::BTN_MIDDLE) begin
                        g0  = pgr_pkg::G_MIDDLE;
                        two = 1'b1;
                    end else if (i_button == pgr_pkg::BTN_RIGHT) begin
                        g0  = pgr_pkg::G_RIGHT;
                        two = 1'b1;
                    end
                end
            end
            pgr_pkg::MODE_MOVE: begin
                if (r_blocked || (!r_held && !r_drag)) begin
                    n_drag = r_drag;
                end else if (!r_drag) begin
                    if (moved_far) begin
                        n_long_on = 1'b0;
                        g0        = pgr_pkg::G_DRAG_START;
                        x0        = r_sx;
                        y0        = r_sy;
                        any       = 1'b1;
                        n_sx      = i_pos_x;
                        n_sy      = i_pos_y;
                        n_mot_on  = 1'b1;
                        n_mot_cnt = '0;
                        n_drag    = 1'b1;
                    end
                end else begin
                    n_sx = i_pos_x;
                    n_sy = i_pos_y;
                    if (!r_mot_on) begin
                        n_mot_on  = 1'b1;
                        n_mot_cnt = '0;
                    end
                end
            end
            pgr_pkg::MODE_TICK: begin
                x0 = r_sx;
                y0 = r_sy;
                x1 = r_sx;
                y1 = r_sy;
                if (r_long_on) begin
                    if (long_fire) begin
                        n_long_on  = 1'b0;
                        n_long_cnt = '0;
                        n_held     = 1'b0;
                    end else begin
                        n_long_cnt = long_next[LW-1:0];
                    end
                end
                if (r_mot_on) begin
                    if (mot_fire) begin
                        n_mot_on  = 1'b0;
                        n_mot_cnt = '0;
                    end else begin
                        n_mot_cnt = mot_next[MW-1:0];
                    end
                end
                // Long click ahead of drag motion when both are due
                any = long_fire || mot_fire;
                two = long_fire && mot_fire;
                g0  = long_fire ? pgr_pkg::G_LONG : pgr_pkg::G_MOTION;
                g1  = pgr_pkg::G_MOTION;
            end
            pgr_pkg::MODE_SCROLL: begin
                x0  = '0;
                y0  = '0;
                any = (i_button != '0);
                g0  = i_button[pgr_pkg::BTN_W-1] ? pgr_pkg::G_SCROLL_DOWN
                                                 : pgr_pkg::G_SCROLL_UP;
            end
            default: begin
                any = 1'b0;
            end
        endcase
    end

    assign o_push.push_one = accept && any && !two;
    assign o_push.push_two = accept && two;
    assign o_evt0 = {g0, x0, y0, !two};
    assign o_evt1 = {g1, x1, y1, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_drag     <= pgr_pkg::MIN_DRAG_RST;
            r_long_ticks   <= pgr_pkg::LONG_TICKS_RST;
            r_motion_ticks <= pgr_pkg::MOTION_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pgr_pkg::CFG_MIN_DRAG:
                    r_min_drag <= i_cfg_wdata[pgr_pkg::MDRAG_W-1:0];
                pgr_pkg::CFG_LONG_TICKS:
                    r_long_ticks <= i_cfg_wdata[LW-1:0];
                pgr_pkg::CFG_MOTION_TICKS:
                    r_motion_ticks <= i_cfg_wdata[MW-1:0];
                default: begin
                    r_min_drag <= r_min_drag;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 1'b0;
            r_blocked  <= 1'b0;
            r_drag     <= 1'b0;
            r_mot_on   <= 1'b0;
            r_long_on  <= 1'b0;
            r_long_cnt <= '0;
            r_mot_cnt  <= '0;
            r_sx       <= '0;
            r_sy       <= '0;
        end else if (accept) begin
            r_held     <= n_held;
            r_blocked  <= n_blocked;
            r_drag     <= n_drag;
            r_mot_on   <= n_mot_on;
            r_long_on  <= n_long_on;
            r_long_cnt <= n_long_cnt;
            r_mot_cnt  <= n_mot_cnt;
            r_sx       <= n_sx;
            r_sy       <= n_sy;
        end
    end

endmodule

/* src/pgr_queue.sv */
// Event queue between front and back: up to two pushes, one pop per cycle.
// Depends on pgr_pkg.
module pgr_queue #(
    parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pgr_pkg::t_push                        i_push,
    input  logic [2*COORD_BITS+pgr_pkg::GEST_W:0] i_evt0,
    input  logic [2*COORD_BITS+pgr_pkg::GEST_W:0] i_evt1,
    input  logic                                  i_pop,
    output logic                                  o_room,
    output logic                                  o_not_empty,
    output logic [2*COORD_BITS+pgr_pkg::GEST_W:0] o_head
);
    localparam int EW = 2 * COORD_BITS + pgr_pkg::GEST_W + 1;
    localparam int PW = pgr_pkg::Q_PTR_W;
    localparam int CW = pgr_pkg::Q_CNT_W;

    logic [EW-1:0] r_mem [pgr_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] wp_plus1;

    assign wp_plus1    = r_wp + 1'b1;
    // Room for a worst-case pair of events
    assign o_room      = (r_cnt <= CW'(pgr_pkg::Q_DEPTH - 2));
    assign o_not_empty = (r_cnt != '0);
    assign o_head      = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push_two) begin
            n_cnt = n_cnt + CW'(2);
        end else if (i_push.push_one) begin
            n_cnt = n_cnt + CW'(1);
        end
        if (i_pop) begin
            n_cnt = n_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_one || i_push.push_two) begin
            r_mem[r_wp] <= i_evt0;
        end
        if (i_push.push_two) begin
            r_mem[wp_plus1] <= i_evt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.push_two) begin
                r_wp <= r_wp + PW'(2);
            end else if (i_push.push_one) begin
                r_wp <= wp_plus1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

/* src/pgr_back.sv */
// Back end: output register that presents one event per transaction and
// refills from the queue head. Depends on pgr_pkg.
module pgr_back #(
    parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_not_empty,
    input  logic [2*COORD_BITS+pgr_pkg::GEST_W:0] i_head,
    output logic                                  o_pop,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic [pgr_pkg::GEST_W-1:0]            o_gesture,
    output logic signed [COORD_BITS-1:0]          o_at_x,
    output logic signed [COORD_BITS-1:0]          o_at_y,
    output logic                                  o_last_of_run
);
    localparam int EW = 2 * COORD_BITS + pgr_pkg::GEST_W + 1;

    logic          r_valid;
    logic [EW-1:0] r_data;

    assign o_pop = i_not_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_not_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_valid       = r_valid;
    assign o_gesture     = r_data[EW-1 -: pgr_pkg::GEST_W];
    assign o_at_x        = r_data[2*COORD_BITS -: COORD_BITS];
    assign o_at_y        = r_data[COORD_BITS -: COORD_BITS];
    assign o_last_of_run = r_data[0];

endmodule

/* src/pointer_gesture_recognizer_unit.sv */
// Pointer gesture recognizer, top level. Order: an accepted transaction's
// events are written into the queue, then loaded one by one into the output register.
// Throughput: one input transaction per cycle while the queue has room for two
// events; the output side moves one event per cycle while i_out_stall is low.
// Reset (synchronous, active low) clears gesture state, queue and output valid,
// and loads register defaults min_drag 5, long 1000 ticks, motion 30 ticks.
module pointer_gesture_recognizer_unit #(
    parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration writes
    input  logic                               i_cfg_we,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pgr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Pointer input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pgr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [pgr_pkg::BTN_W-1:0]   i_button,
    input  logic signed [COORD_BITS-1:0]       i_pos_x,
    input  logic signed [COORD_BITS-1:0]       i_pos_y,
    input  logic                               i_press_claimed,
    // Gesture event channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pgr_pkg::GEST_W-1:0]         o_gesture,
    output logic signed [COORD_BITS-1:0]       o_at_x,
    output logic signed [COORD_BITS-1:0]       o_at_y,
    output logic                               o_last_of_run
);
    localparam int EW = 2 * COORD_BITS + pgr_pkg::GEST_W + 1;

    pgr_pkg::t_push push;
    logic [EW-1:0]  evt0, evt1, head;
    logic           room, not_empty, pop;

    // Input is taken whenever the queue can absorb a full pair of events;
    // the stall does not look at the output side directly.
    assign o_in_stall = !room;

    // Front: registers, state, classification into up to two events
    pgr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_in_valid),
        .i_mode          (i_mode),
        .i_button        (i_button),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_press_claimed (i_press_claimed),
        .i_room          (room),
        .o_push          (push),
        .o_evt0          (evt0),
        .o_evt1          (evt1)
    );

    // Four-entry event queue decoupling front and back
    pgr_queue #(.COORD_BITS(COORD_BITS)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_evt0      (evt0),
        .i_evt1      (evt1),
        .i_pop       (pop),
        .o_room      (room),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    // Back: output register, one event per transaction
    pgr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_not_empty   (not_empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_gesture     (o_gesture),
        .o_at_x        (o_at_x),
        .o_at_y        (o_at_y),
        .o_last_of_run (o_last_of_run)
    );

endmodule
